// ----- sv/rjb_pkg.sv -----
// Shared types and codes for the jitter buffer slot manager.
`timescale 1ns / 1ps

package rjb_pkg;

   // slot status codes
   localparam logic [1:0] ST_FREE    = 2'd0;
   localparam logic [1:0] ST_OK      = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   // arrival rating codes
   localparam logic [2:0] RT_START    = 3'd0;
   localparam logic [2:0] RT_DUP      = 3'd1;
   localparam logic [2:0] RT_EXPECTED = 3'd2;
   localparam logic [2:0] RT_EARLY    = 3'd3;
   localparam logic [2:0] RT_LATE     = 3'd4;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_CLEAR,
      OP_MOD_SEQ,
      OP_MOD_FRONT,
      OP_MOD_WALK,
      OP_RD_SEQ,
      OP_RD_FRONT,
      OP_LATCH_SEQ,
      OP_EVAL,
      OP_POINTERS,
      OP_WALK_INIT,
      OP_WALK,
      OP_COMMIT,
      OP_TAKE,
      OP_LOAD_OUT
   } dp_op_type;

   typedef struct packed {
      logic mod_done;
      logic take;
      logic ready;
      logic dup;
      logic flush;
      logic walk_zero;
      logic walk_last;
      logic clear_last;
   } dp_status_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] seq;
   } slot_entry_type;

endpackage

// ----- sv/rjb_mod.sv -----
// Pipelined sequence-number to slot reduction (value modulo CAPACITY).
`timescale 1ns / 1ps

module rjb_mod #(
   parameter int CAPACITY = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [15:0]                 value,
   output logic                        done,
   output logic [$clog2(CAPACITY)-1:0] slot
);

   localparam int SW = $clog2(CAPACITY);
   localparam int RW = SW + 1;
   // floor(2^32 / CAPACITY): quotient estimate is low by at most one
   localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / CAPACITY);
   localparam logic [15:0]   CAP16 = 16'(CAPACITY);
   localparam logic [RW-1:0] CAP_R = RW'(CAPACITY);

   logic          v1_ff, v2_ff, v3_ff;
   logic [47:0]   prod_ff;
   logic [15:0]   val1_ff, val2_ff, qc_ff;
   logic [RW-1:0] rem_ff;
   logic [15:0]   diff;
   logic [RW-1:0] rem_sub;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign diff = val2_ff - qc_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 48'(value) * 48'(RECIP);
      val1_ff <= value;
      qc_ff   <= prod_ff[47:32] * CAP16;
      val2_ff <= val1_ff;
      rem_ff  <= diff[RW-1:0];
   end

   assign rem_sub = rem_ff - CAP_R;
   assign slot    = (rem_ff >= CAP_R) ? rem_sub[SW-1:0] : rem_ff[SW-1:0];
   assign done    = v3_ff;

endmodule

// ----- sv/rjb_dp.sv -----
// Datapath: slot memory, pointers, rating logic and result registers.
`timescale 1ns / 1ps

module rjb_dp #(
   parameter int CAPACITY = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rjb_pkg::dp_op_type    op,
   input  logic                  req_action,
   input  logic [15:0]           req_seq_number,
   input  logic [6:0]            desired_fill,
   output rjb_pkg::dp_status_type status,
   output logic                  rsp_accepted,
   output logic [2:0]            rsp_rating,
   output logic                  rsp_flushed,
   output logic                  rsp_take_valid,
   output logic                  rsp_take_missing,
   output logic [7:0]            rsp_slot_index,
   output logic [15:0]           rsp_seq_out,
   output logic                  rsp_ready_res
);

   localparam int SW       = $clog2(CAPACITY);
   // a walk that wraps past 0xFFFF revisits slots unless CAPACITY divides 2^16
   localparam int WALK_MAX = ((65536 % CAPACITY) == 0) ? CAPACITY : 2 * CAPACITY;
   localparam int CW       = $clog2(WALK_MAX + 1);
   localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);
   localparam logic [15:0]   CAP_M1    = 16'(CAPACITY - 1);
   localparam logic [15:0]   WALK16    = 16'(WALK_MAX);
   localparam logic [CW-1:0] WALK_CNT  = CW'(WALK_MAX);

   rjb_pkg::slot_entry_type slot_mem [CAPACITY];
   rjb_pkg::slot_entry_type rd_data_ff;
   rjb_pkg::slot_entry_type wr_data;
   logic [SW-1:0]           wr_addr;
   logic                    wr_en, rd_en;

   // pointers and flags
   logic [15:0]   front_ff, end_ff;
   logic          ready_ff;
   logic [SW-1:0] clr_ptr_ff;

   // per-item working registers
   logic          action_ff;
   logic [15:0]   seq_ff;
   logic [SW-1:0] sslot_ff, fslot_ff, walk_slot_ff;
   logic [1:0]    st_s_ff;
   logic [15:0]   sq_s_ff;
   logic          dup_ff, flush_ff, late_ff, restart_ff;
   logic [CW-1:0] walk_cnt_ff;
   logic [15:0]   walk_seq_ff;

   logic          res_accepted_ff, res_flushed_ff, res_tvalid_ff, res_tmissing_ff;
   logic [2:0]    res_rating_ff;
   logic [7:0]    res_sidx_ff;
   logic [15:0]   res_sout_ff;

   logic          rsp_accepted_ff, rsp_flushed_ff, rsp_tvalid_ff, rsp_tmissing_ff;
   logic          rsp_ready_ff;
   logic [2:0]    rsp_rating_ff;
   logic [7:0]    rsp_sidx_ff;
   logic [15:0]   rsp_sout_ff;

   // slot reduction unit
   logic          mod_start, mod_done;
   logic [15:0]   mod_value;
   logic [SW-1:0] mod_slot;

   rjb_mod #(.CAPACITY(CAPACITY)) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .value (mod_value),
      .done  (mod_done),
      .slot  (mod_slot)
   );

   assign mod_start = (op == rjb_pkg::OP_MOD_SEQ) || (op == rjb_pkg::OP_MOD_FRONT) ||
                      (op == rjb_pkg::OP_MOD_WALK);

   always_comb begin
      priority if (op == rjb_pkg::OP_MOD_FRONT) mod_value = front_ff;
      else if (op == rjb_pkg::OP_MOD_WALK)      mod_value = walk_seq_ff;
      else                                      mod_value = seq_ff;
   end

   // rating and flush decision
   logic [15:0]        seq_diff;
   logic signed [16:0] dist_s, df_s;
   logic               is_dup, front_free, far;
   logic [2:0]         rating_calc;

   assign seq_diff   = seq_ff - end_ff;
   assign dist_s     = signed'({seq_diff[15], seq_diff});
   assign df_s       = signed'({10'd0, desired_fill});
   assign is_dup     = (sq_s_ff == seq_ff) && (st_s_ff == rjb_pkg::ST_OK);
   assign front_free = (rd_data_ff.status == rjb_pkg::ST_FREE);
   assign far        = (dist_s >= df_s) || (dist_s <= -df_s);

   always_comb begin
      priority if (front_free)                        rating_calc = rjb_pkg::RT_START;
      else if ((dist_s > 17'sd0) && (dist_s < df_s))  rating_calc = rjb_pkg::RT_EARLY;
      else if (seq_diff == 16'd0)                     rating_calc = rjb_pkg::RT_EXPECTED;
      else if ((sq_s_ff == seq_ff) && (st_s_ff == rjb_pkg::ST_MISSING))
                                                      rating_calc = rjb_pkg::RT_LATE;
      else                                            rating_calc = rjb_pkg::RT_START;
   end

   // pointer update and gap walk setup
   logic [15:0]   fill_old, end_base, gap, walk_start, end_new, fill_new, df16;
   logic [CW-1:0] walk_cnt_calc;

   assign df16     = {9'd0, desired_fill};
   assign fill_old = end_ff - front_ff - 16'd1;
   assign end_base = restart_ff ? seq_ff : end_ff;
   assign gap      = seq_ff - end_base;

   // earlier skipped numbers would be overwritten in the ring anyway
   always_comb begin
      priority if (late_ff)  walk_cnt_calc = '0;
      else if (gap > WALK16) walk_cnt_calc = WALK_CNT;
      else                   walk_cnt_calc = gap[CW-1:0];
   end

   assign walk_start = seq_ff - 16'(walk_cnt_calc);
   assign end_new    = late_ff ? end_ff : seq_ff + 16'd1;
   assign fill_new   = end_new - front_ff - 16'd1;

   logic [15:0] sslot_wide, fslot_wide;
   assign sslot_wide = 16'(sslot_ff);
   assign fslot_wide = 16'(fslot_ff);

   // memory ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ptr_ff;
      wr_data = '{status: rjb_pkg::ST_FREE, seq: 16'd0};
      unique case (op)
         rjb_pkg::OP_CLEAR: begin
            wr_en = 1'b1;
         end
         rjb_pkg::OP_WALK: begin
            wr_en   = 1'b1;
            wr_addr = walk_slot_ff;
            wr_data = '{status: rjb_pkg::ST_MISSING, seq: walk_seq_ff};
         end
         rjb_pkg::OP_COMMIT: begin
            wr_en   = 1'b1;
            wr_addr = sslot_ff;
            wr_data = '{status: rjb_pkg::ST_OK, seq: seq_ff};
         end
         rjb_pkg::OP_TAKE: begin
            wr_en   = !front_free;
            wr_addr = fslot_ff;
            wr_data = '{status: rjb_pkg::ST_FREE, seq: rd_data_ff.seq};
         end
         default: begin
         end
      endcase
   end

   assign rd_en = (op == rjb_pkg::OP_RD_SEQ) || (op == rjb_pkg::OP_RD_FRONT);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[mod_slot];
      end
   end

   // pointers, ready flag and clear sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff   <= 16'd0;
         end_ff     <= 16'd0;
         ready_ff   <= 1'b0;
         clr_ptr_ff <= '0;
      end else begin
         unique case (op)
            rjb_pkg::OP_CLEAR: begin
               clr_ptr_ff <= (clr_ptr_ff == LAST_SLOT) ? '0 : clr_ptr_ff + 1'b1;
            end
            rjb_pkg::OP_EVAL: begin
               if (!is_dup && far) ready_ff <= 1'b0;
            end
            rjb_pkg::OP_POINTERS: begin
               if (restart_ff) begin
                  front_ff <= seq_ff;
                  end_ff   <= seq_ff;
               end else if (fill_old >= CAP_M1) begin
                  front_ff <= end_ff - df16;
               end
            end
            rjb_pkg::OP_COMMIT: begin
               end_ff <= end_new;
               if (fill_new >= df16) ready_ff <= 1'b1;
            end
            rjb_pkg::OP_TAKE: begin
               front_ff <= front_ff + 16'd1;
            end
            default: begin
            end
         endcase
      end
   end

   // per-item registers
   always_ff @(posedge clock) begin
      unique case (op)
         rjb_pkg::OP_CAPTURE: begin
            action_ff       <= req_action;
            seq_ff          <= req_seq_number;
            res_accepted_ff <= 1'b0;
            res_rating_ff   <= rjb_pkg::RT_START;
            res_flushed_ff  <= 1'b0;
            res_tvalid_ff   <= 1'b0;
            res_tmissing_ff <= 1'b0;
            res_sidx_ff     <= 8'd0;
            res_sout_ff     <= 16'd0;
         end
         rjb_pkg::OP_RD_SEQ: begin
            sslot_ff <= mod_slot;
         end
         rjb_pkg::OP_RD_FRONT: begin
            fslot_ff <= mod_slot;
         end
         rjb_pkg::OP_LATCH_SEQ: begin
            st_s_ff <= rd_data_ff.status;
            sq_s_ff <= rd_data_ff.seq;
         end
         rjb_pkg::OP_EVAL: begin
            dup_ff          <= is_dup;
            flush_ff        <= !is_dup && far;
            late_ff         <= !is_dup && (rating_calc == rjb_pkg::RT_LATE);
            restart_ff      <= far || front_free;
            res_accepted_ff <= !is_dup;
            res_rating_ff   <= is_dup ? rjb_pkg::RT_DUP : rating_calc;
            res_flushed_ff  <= !is_dup && far;
            res_sidx_ff     <= sslot_wide[7:0];
            res_sout_ff     <= seq_ff;
         end
         rjb_pkg::OP_POINTERS: begin
            walk_cnt_ff <= walk_cnt_calc;
            walk_seq_ff <= walk_start;
         end
         rjb_pkg::OP_WALK_INIT: begin
            walk_slot_ff <= mod_slot;
         end
         rjb_pkg::OP_WALK: begin
            walk_seq_ff  <= walk_seq_ff + 16'd1;
            // sequence 0 after 0xFFFF always lands in slot 0
            walk_slot_ff <= ((walk_slot_ff == LAST_SLOT) || (walk_seq_ff == 16'hFFFF)) ?
                            '0 : walk_slot_ff + 1'b1;
            walk_cnt_ff  <= walk_cnt_ff - 1'b1;
         end
         rjb_pkg::OP_TAKE: begin
            if (!front_free) begin
               res_tvalid_ff   <= 1'b1;
               res_tmissing_ff <= (rd_data_ff.status == rjb_pkg::ST_MISSING);
               res_sidx_ff     <= fslot_wide[7:0];
               res_sout_ff     <= rd_data_ff.seq;
            end
         end
         rjb_pkg::OP_LOAD_OUT: begin
            rsp_accepted_ff <= res_accepted_ff;
            rsp_rating_ff   <= res_rating_ff;
            rsp_flushed_ff  <= res_flushed_ff;
            rsp_tvalid_ff   <= res_tvalid_ff;
            rsp_tmissing_ff <= res_tmissing_ff;
            rsp_sidx_ff     <= res_sidx_ff;
            rsp_sout_ff     <= res_sout_ff;
            rsp_ready_ff    <= ready_ff;
         end
         default: begin
         end
      endcase
   end

   assign status.mod_done   = mod_done;
   assign status.take       = action_ff;
   assign status.ready      = ready_ff;
   assign status.dup        = dup_ff;
   assign status.flush      = flush_ff;
   assign status.walk_zero  = (walk_cnt_ff == '0);
   assign status.walk_last  = (walk_cnt_ff == CW'(1));
   assign status.clear_last = (clr_ptr_ff == LAST_SLOT);

   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_rating       = rsp_rating_ff;
   assign rsp_flushed      = rsp_flushed_ff;
   assign rsp_take_valid   = rsp_tvalid_ff;
   assign rsp_take_missing = rsp_tmissing_ff;
   assign rsp_slot_index   = rsp_sidx_ff;
   assign rsp_seq_out      = rsp_sout_ff;
   assign rsp_ready_res    = rsp_ready_ff;

endmodule

// ----- sv/rjb_ctrl.sv -----
// Controller: sequences clear sweeps, arrivals and takes over the datapath.
`timescale 1ns / 1ps

module rjb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rjb_pkg::dp_status_type status,
   output rjb_pkg::dp_op_type    op
);

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_MOD_SEQ,
      S_WAIT_SEQ,
      S_LATCH_SEQ,
      S_MOD_FRONT,
      S_WAIT_FRONT,
      S_EVAL,
      S_DECIDE,
      S_FLUSH,
      S_POINTERS,
      S_ROUTE,
      S_MOD_WALK,
      S_WAIT_WALK,
      S_WALK,
      S_COMMIT,
      S_TAKE,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      load_out;

   always_comb begin
      state_in = state_ff;
      op       = rjb_pkg::OP_NONE;
      load_out = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            op = rjb_pkg::OP_CLEAR;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op       = rjb_pkg::OP_CAPTURE;
               state_in = S_START;
            end
         end
         S_START: begin
            priority if (!status.take) state_in = S_MOD_SEQ;
            else if (status.ready)     state_in = S_MOD_FRONT;
            else                       state_in = S_FINISH;
         end
         S_MOD_SEQ: begin
            op       = rjb_pkg::OP_MOD_SEQ;
            state_in = S_WAIT_SEQ;
         end
         S_WAIT_SEQ: begin
            if (status.mod_done) begin
               op       = rjb_pkg::OP_RD_SEQ;
               state_in = S_LATCH_SEQ;
            end
         end
         S_LATCH_SEQ: begin
            op       = rjb_pkg::OP_LATCH_SEQ;
            state_in = S_MOD_FRONT;
         end
         S_MOD_FRONT: begin
            op       = rjb_pkg::OP_MOD_FRONT;
            state_in = S_WAIT_FRONT;
         end
         S_WAIT_FRONT: begin
            if (status.mod_done) begin
               op       = rjb_pkg::OP_RD_FRONT;
               state_in = status.take ? S_TAKE : S_EVAL;
            end
         end
         S_EVAL: begin
            op       = rjb_pkg::OP_EVAL;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            priority if (status.dup) state_in = S_FINISH;
            else if (status.flush)   state_in = S_FLUSH;
            else                     state_in = S_POINTERS;
         end
         S_FLUSH: begin
            op = rjb_pkg::OP_CLEAR;
            if (status.clear_last) state_in = S_POINTERS;
         end
         S_POINTERS: begin
            op       = rjb_pkg::OP_POINTERS;
            state_in = S_ROUTE;
         end
         S_ROUTE: begin
            state_in = status.walk_zero ? S_COMMIT : S_MOD_WALK;
         end
         S_MOD_WALK: begin
            op       = rjb_pkg::OP_MOD_WALK;
            state_in = S_WAIT_WALK;
         end
         S_WAIT_WALK: begin
            if (status.mod_done) begin
               op       = rjb_pkg::OP_WALK_INIT;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            op = rjb_pkg::OP_WALK;
            if (status.walk_last) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            op       = rjb_pkg::OP_COMMIT;
            state_in = S_FINISH;
         end
         S_TAKE: begin
            op       = rjb_pkg::OP_TAKE;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               op       = rjb_pkg::OP_LOAD_OUT;
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/rtp_jitter_buffer_slot_manager.sv -----
// Top level: register port, controller and datapath of the slot manager.
// Arrival: a gap marks the skipped numbers missing (at most CAPACITY, twice that if CAPACITY
//   does not divide 65536), and a flush first clears every slot.
// One item at a time: the next is accepted in the cycle after its result loads, which waits
//   while the previous result is held; 3-stage slot reduction.
// Reset: synchronous; a clearing pass frees every slot, no item accepted meanwhile.
`timescale 1ns / 1ps

module rtp_jitter_buffer_slot_manager #(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [15:0] req_seq_number,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_rating,
   output logic        rsp_flushed,
   output logic        rsp_take_valid,
   output logic        rsp_take_missing,
   output logic [7:0]  rsp_slot_index,
   output logic [15:0] rsp_seq_out,
   output logic        rsp_ready_res,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [6:0] FILL_RESET = 7'd64;

   logic [6:0]             desired_fill_ff;
   rjb_pkg::dp_op_type     op;
   rjb_pkg::dp_status_type status;

   // one register, mirrored at addresses 0 to 3; paddr[2] set is past the end
   always_ff @(posedge clock) begin
      if (reset) begin
         desired_fill_ff <= FILL_RESET;
      end else if (psel && penable && pwrite && !paddr[2]) begin
         desired_fill_ff <= pwdata[6:0];
      end
   end

   assign prdata = paddr[2] ? 32'd0 : {25'd0, desired_fill_ff};
   assign pready = 1'b1;

   rjb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .op        (op)
   );

   rjb_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .req_action       (req_action),
      .req_seq_number   (req_seq_number),
      .desired_fill     (desired_fill_ff),
      .status           (status),
      .rsp_accepted     (rsp_accepted),
      .rsp_rating       (rsp_rating),
      .rsp_flushed      (rsp_flushed),
      .rsp_take_valid   (rsp_take_valid),
      .rsp_take_missing (rsp_take_missing),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_seq_out      (rsp_seq_out),
      .rsp_ready_res    (rsp_ready_res)
   );

endmodule

// ----- bench/rtp_jitter_buffer_slot_manager_checker.sv -----
// Jitter buffer slot manager checker: tracks slots, predicts each result, compares.
`timescale 1ns / 1ps

module rtp_jitter_buffer_slot_manager_checker #(
   parameter int         CAPACITY  = 256,
   parameter logic [2:0] FILL_ADDR = 3'd0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_action,
   input  logic [15:0] req_seq_number,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_accepted,
   input  logic [2:0]  rsp_rating,
   input  logic        rsp_flushed,
   input  logic        rsp_take_valid,
   input  logic        rsp_take_missing,
   input  logic [7:0]  rsp_slot_index,
   input  logic [15:0] rsp_seq_out,
   input  logic        rsp_ready_res,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          fail_count,
   output int          outstanding
);

   typedef struct packed {
      logic        accepted;
      logic [2:0]  rating;
      logic        flushed;
      logic        take_valid;
      logic        take_missing;
      logic [7:0]  slot_index;
      logic [15:0] seq_out;
      logic        ready_res;
   } playout_type;

   logic [1:0]  slot_st [CAPACITY];
   logic [15:0] slot_sq [CAPACITY];
   logic [15:0] front_ptr;
   logic [15:0] end_ptr;
   logic        ready_flag;
   logic [6:0]  fill_cfg;
   playout_type pending_outcomes [$];
   int          errs = 0;

   function automatic void check_field(input string name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
         errs++;
      end
   endfunction

   // one arrival or take applied to the slot ring
   function automatic playout_type slot_outcome(input logic take, input logic [15:0] seq);
      playout_type r;
      int          slot;
      int          front_slot;
      int          sdist;
      logic [15:0] diff;
      logic [15:0] level;
      logic [15:0] pos;
      logic [1:0]  st;
      r = '0;
      if (!take) begin
         slot = int'(seq) % CAPACITY;
         diff = seq - end_ptr;
         sdist = diff[15] ? int'(diff) - 65536 : int'(diff);
         r.slot_index = 8'(slot);
         r.seq_out = seq;
         if (slot_sq[slot] == seq && slot_st[slot] == rjb_pkg::ST_OK) begin
            r.rating = rjb_pkg::RT_DUP;
         end else begin
            front_slot = int'(front_ptr) % CAPACITY;
            if (slot_st[front_slot] == rjb_pkg::ST_FREE) r.rating = rjb_pkg::RT_START;
            else if (sdist > 0 && sdist < int'(fill_cfg)) r.rating = rjb_pkg::RT_EARLY;
            else if (sdist == 0) r.rating = rjb_pkg::RT_EXPECTED;
            else if (slot_sq[slot] == seq && slot_st[slot] == rjb_pkg::ST_MISSING)
               r.rating = rjb_pkg::RT_LATE;
            else r.rating = rjb_pkg::RT_START;

            if ((sdist < 0 ? -sdist : sdist) >= int'(fill_cfg)) begin
               foreach (slot_st[j]) slot_st[j] = rjb_pkg::ST_FREE;
               ready_flag = 1'b0;
               r.flushed = 1'b1;
            end

            level = end_ptr - front_ptr - 16'd1;
            if (slot_st[front_slot] == rjb_pkg::ST_FREE) begin
               front_ptr = seq;
               end_ptr = seq;
            end else if (int'(level) >= CAPACITY - 1) begin
               front_ptr = end_ptr - {9'd0, fill_cfg};
            end

            if (r.rating != rjb_pkg::RT_LATE) begin
               for (pos = end_ptr; pos != seq; pos = pos + 16'd1) begin
                  slot_st[int'(pos) % CAPACITY] = rjb_pkg::ST_MISSING;
                  slot_sq[int'(pos) % CAPACITY] = pos;
               end
               end_ptr = seq + 16'd1;
            end
            slot_sq[slot] = seq;
            slot_st[slot] = rjb_pkg::ST_OK;
            r.accepted = 1'b1;
            level = end_ptr - front_ptr - 16'd1;
            if (level >= {9'd0, fill_cfg}) ready_flag = 1'b1;
         end
      end else if (ready_flag) begin
         slot = int'(front_ptr) % CAPACITY;
         st = slot_st[slot];
         front_ptr = front_ptr + 16'd1;
         if (st == rjb_pkg::ST_OK || st == rjb_pkg::ST_MISSING) begin
            r.take_valid = 1'b1;
            r.take_missing = (st == rjb_pkg::ST_MISSING);
            r.slot_index = 8'(slot);
            r.seq_out = slot_sq[slot];
            slot_st[slot] = rjb_pkg::ST_FREE;
         end
      end
      r.ready_res = ready_flag;
      return r;
   endfunction

   always @(posedge clock) begin
      playout_type want;
      if (reset) begin
         foreach (slot_st[j]) begin
            slot_st[j] = rjb_pkg::ST_FREE;
            slot_sq[j] = 16'd0;
         end
         front_ptr = 16'd0;
         end_ptr = 16'd0;
         ready_flag = 1'b0;
         fill_cfg = 7'd64;
         pending_outcomes.delete();
      end else begin
         if (psel && penable && pready && paddr == FILL_ADDR) begin
            if (pwrite) fill_cfg = pwdata[6:0];
            else check_field("desired_fill", {25'd0, fill_cfg}, prdata);
         end
         if (req_valid && req_ready)
            pending_outcomes.push_back(slot_outcome(req_action, req_seq_number));
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               $error("result item arrived with no item outstanding");
               errs++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
               check_field("rating", 32'(want.rating), 32'(rsp_rating));
               check_field("flushed", 32'(want.flushed), 32'(rsp_flushed));
               check_field("take_valid", 32'(want.take_valid), 32'(rsp_take_valid));
               check_field("take_missing", 32'(want.take_missing), 32'(rsp_take_missing));
               check_field("slot_index", 32'(want.slot_index), 32'(rsp_slot_index));
               check_field("seq_out", 32'(want.seq_out), 32'(rsp_seq_out));
               check_field("ready_res", 32'(want.ready_res), 32'(rsp_ready_res));
            end
         end
      end
      fail_count <= errs;
      outstanding <= pending_outcomes.size();
   end

endmodule

// ----- bench/rtp_jitter_buffer_slot_manager_tb.sv -----
// Testbench top: clock, reset, stimulus, receiver pacing, watchdog and verdict.
`timescale 1ns / 1ps

module rtp_jitter_buffer_slot_manager_tb;

   localparam int         CAPACITY      = 256;
   localparam logic [2:0] FILL_ADDR     = 3'd0;
   localparam int         SETTLE_CYCLES = 600;   // worst arrival: gap walk plus flush
   localparam int         HOLD_CYCLES   = 600;
   localparam int         STALL_LIMIT   = 8000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [15:0] req_seq_number = 16'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_accepted;
   logic [2:0]  rsp_rating;
   logic        rsp_flushed;
   logic        rsp_take_valid;
   logic        rsp_take_missing;
   logic [7:0]  rsp_slot_index;
   logic [15:0] rsp_seq_out;
   logic        rsp_ready_res;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   int          fail_count;
   int          outstanding;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   logic        hold_arm = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_cnt = 0;
   int          quiet = 0;
   int          n_arrivals = 0;
   int          n_takes = 0;
   int          n_settings = 0;
   logic [15:0] cursor = 16'd0;

   always #2 clock = ~clock;

   rtp_jitter_buffer_slot_manager #(.CAPACITY(CAPACITY)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_seq_number(req_seq_number),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_accepted(rsp_accepted), .rsp_rating(rsp_rating), .rsp_flushed(rsp_flushed),
      .rsp_take_valid(rsp_take_valid), .rsp_take_missing(rsp_take_missing),
      .rsp_slot_index(rsp_slot_index), .rsp_seq_out(rsp_seq_out),
      .rsp_ready_res(rsp_ready_res),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   rtp_jitter_buffer_slot_manager_checker #(
      .CAPACITY(CAPACITY), .FILL_ADDR(FILL_ADDR)
   ) i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_seq_number(req_seq_number),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_accepted(rsp_accepted), .rsp_rating(rsp_rating), .rsp_flushed(rsp_flushed),
      .rsp_take_valid(rsp_take_valid), .rsp_take_missing(rsp_take_missing),
      .rsp_slot_index(rsp_slot_index), .rsp_seq_out(rsp_seq_out),
      .rsp_ready_res(rsp_ready_res),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   // receiver pacing, plus one long hold-off when armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         rsp_ready <= 1'b0;
         hold_cnt <= hold_cnt - 1;
      end else if (hold_arm && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_cnt <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet == STALL_LIMIT) begin
         $display("FAIL rtp_jitter_buffer_slot_manager");
         $finish;
      end
   end

   task automatic csr_cycle(input logic wr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= FILL_ADDR;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic offer_item(input logic take, input logic [15:0] seq);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= take;
      req_seq_number <= seq;
      do @(posedge clock); while (!req_ready);
      if (take) n_takes++;
      else n_arrivals++;
   endtask

   // random takes, else mostly in-order arrivals near the cursor; some gaps, stragglers and far jumps
   task automatic random_item(input int take_pct);
      logic [15:0] seq;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < take_pct) begin
         offer_item(1'b1, 16'($urandom));
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            seq = cursor;
            cursor = cursor + 16'd1;
         end else if (pick < 75) begin
            seq = cursor + 16'($urandom_range(1, 6));
            cursor = seq + 16'd1;
         end else if (pick < 92) begin
            seq = cursor - 16'($urandom_range(1, 10));
         end else begin
            seq = 16'($urandom);
            cursor = seq + 16'd1;
         end
         offer_item(1'b0, seq);
      end
   endtask

   task automatic drain_block;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [6:0] fill, input int items, input int idle,
                            input int stall, input int take_pct);
      drain_block();
      csr_cycle(1'b1, {25'd0, fill});
      csr_cycle(1'b0, 32'd0);
      n_settings++;
      send_idle_pct = idle;
      rsp_stall_pct <= stall;
      repeat (items) random_item(take_pct);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // clearing pass after reset
      repeat (CAPACITY + 16) @(posedge clock);
      csr_cycle(1'b0, 32'd0);
      csr_cycle(1'b1, 32'd4);
      csr_cycle(1'b0, 32'd0);
      n_settings++;

      // directed: take before ready, wrap, duplicate, early, late, flushes, long walk
      offer_item(1'b1, 16'hFFFF);
      offer_item(1'b0, 16'hFFFD);
      offer_item(1'b0, 16'hFFFD);
      offer_item(1'b0, 16'hFFFE);
      offer_item(1'b0, 16'h0001);
      offer_item(1'b0, 16'h0000);
      offer_item(1'b0, 16'h0002);
      offer_item(1'b1, 16'h0000);
      offer_item(1'b1, 16'h0000);
      offer_item(1'b1, 16'h0000);
      offer_item(1'b0, 16'hFFFF);
      offer_item(1'b0, 16'h8000);
      offer_item(1'b0, 16'h7FFF);
      offer_item(1'b1, 16'hFFFF);
      offer_item(1'b1, 16'h0000);
      offer_item(1'b0, 16'h0000);
      offer_item(1'b0, 16'h0001);
      offer_item(1'b0, 16'h0001);
      offer_item(1'b1, 16'h0000);
      offer_item(1'b1, 16'h0000);
      offer_item(1'b1, 16'h0000);
      cursor = 16'h0002;

      run_phase(7'd1, 150, 0, 0, 30);
      run_phase(7'd127, 200, 45, 0, 15);
      run_phase(7'd0, 40, 0, 45, 30);
      run_phase(7'($urandom_range(2, 20)), 200, 16, 16, 35);

      // receiver holds off while items keep coming
      drain_block();
      csr_cycle(1'b1, 32'd8);
      n_settings++;
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      hold_arm <= 1'b1;
      repeat (60) random_item(25);

      run_phase(7'd64, 230, 16, 45, 25);
      drain_block();

      $display("Covered %0d arrivals and %0d takes over %0d fill settings", n_arrivals,
               n_takes, n_settings);
      $display("(fill 0, 1, 127 included) with sender gaps, receiver stalls and a long hold");
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS rtp_jitter_buffer_slot_manager");
      end else begin
         $display("FAIL rtp_jitter_buffer_slot_manager");
      end
      $finish;
   end

endmodule
